// ----- hw/rtl/pdc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdc_pkg
// Shared constants, register map and configuration word for the pendulum
// PID duty controller.
// ----------------------------------------------------------------------------
package pdc_pkg;

	// default build widths
	localparam int ADC_BITS_DEF       = 10;
	localparam int DUTY_FRAC_BITS_DEF = 15;

	// register field widths
	localparam int KP_W    = 24;
	localparam int KI_W    = 24;
	localparam int KD_W    = 26;
	localparam int LIM_W   = 29;
	localparam int ADCFG_W = 10;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 29;

	// integrator width and fixed-point positions of the PID sum
	localparam int INT_W      = 30;
	localparam int GAIN_SHIFT = 24;
	localparam int SUM_FRAC   = 32;

	// register reset values
	localparam logic [KP_W-1:0]    KP_RST       = KP_W'(338127);
	localparam logic [KI_W-1:0]    KI_RST       = KI_W'(7091);
	localparam logic [KD_W-1:0]    KD_RST       = KD_W'(38039296);
	localparam logic [LIM_W-1:0]   LIM_RST      = LIM_W'(275657000);
	localparam logic [ADCFG_W-1:0] ZERO_RST     = ADCFG_W'(423);
	localparam logic [ADCFG_W-1:0] SAFE_HI_RST  = ADCFG_W'(520);
	localparam logic [ADCFG_W-1:0] SAFE_LO_RST  = ADCFG_W'(250);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KP       = 3'd0,
		REG_KI       = 3'd1,
		REG_KD       = 3'd2,
		REG_INT_LIM  = 3'd3,
		REG_ZERO     = 3'd4,
		REG_SAFE_HI  = 3'd5,
		REG_SAFE_LO  = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [KP_W-1:0]    kp;
		logic [KI_W-1:0]    ki;
		logic [KD_W-1:0]    kd;
		logic [LIM_W-1:0]   int_lim;
		logic [ADCFG_W-1:0] zero_offset;
		logic [ADCFG_W-1:0] safe_high;
		logic [ADCFG_W-1:0] safe_low;
	} cfg_t;

	// width of the error: sample and offset, whichever is wider, plus sign
	function automatic int err_width(input int adc_bits);
		return ((adc_bits > ADCFG_W) ? adc_bits : ADCFG_W) + 1;
	endfunction

	// width of the full PID sum with SUM_FRAC fraction bits
	function automatic int tot_width(input int adc_bits);
		return err_width(adc_bits) + 1 + KD_W + 1 + GAIN_SHIFT + 2;
	endfunction

endpackage

// ----- hw/rtl/pdc_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdc_cfg_regs
// Configuration register file: gains, integrator clamp, zero offset and the
// safe band, written one word at a time over the configuration channel.
// ----------------------------------------------------------------------------
module pdc_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pdc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pdc_pkg::CFG_DATA_W-1:0] cfg_data,
	output pdc_pkg::cfg_t                  cfg
);
	import pdc_pkg::*;

	cfg_t cfg_q;

	// always able to take a word
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// decode the index and update the addressed register; drop unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp          <= KP_RST;
			cfg_q.ki          <= KI_RST;
			cfg_q.kd          <= KD_RST;
			cfg_q.int_lim     <= LIM_RST;
			cfg_q.zero_offset <= ZERO_RST;
			cfg_q.safe_high   <= SAFE_HI_RST;
			cfg_q.safe_low    <= SAFE_LO_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				REG_KP:      cfg_q.kp          <= cfg_data[KP_W-1:0];
				REG_KI:      cfg_q.ki          <= cfg_data[KI_W-1:0];
				REG_KD:      cfg_q.kd          <= cfg_data[KD_W-1:0];
				REG_INT_LIM: cfg_q.int_lim     <= cfg_data[LIM_W-1:0];
				REG_ZERO:    cfg_q.zero_offset <= cfg_data[ADCFG_W-1:0];
				REG_SAFE_HI: cfg_q.safe_high   <= cfg_data[ADCFG_W-1:0];
				REG_SAFE_LO: cfg_q.safe_low    <= cfg_data[ADCFG_W-1:0];
				default:     cfg_q             <= cfg_q;
			endcase
		end
	end

endmodule

// ----- hw/rtl/pdc_pid_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdc_pid_core
// Input register, error / derivative / clamped trapezoidal integral, the three
// gain products and their sum. Error and integrator state advance as each
// word leaves the input register.
// ----------------------------------------------------------------------------
module pdc_pid_core #(
	parameter int ADC_BITS = pdc_pkg::ADC_BITS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  pdc_pkg::cfg_t                             cfg,
	input  logic [ADC_BITS-1:0]                       sample,
	input  logic                                      sample_valid,
	output logic                                      sample_stall,
	input  logic                                      take,
	output logic                                      word_valid,
	output logic                                      word_cut,
	output logic signed [pdc_pkg::tot_width(ADC_BITS)-1:0] word_total
);
	import pdc_pkg::*;

	localparam int ERR_W  = err_width(ADC_BITS);
	localparam int CMP_W  = ERR_W - 1;
	localparam int DIFF_W = ERR_W + 1;
	localparam int ISUM_W = INT_W + 2;
	localparam int P_W    = ERR_W + KP_W + 1;
	localparam int D_W    = DIFF_W + KD_W + 1;
	localparam int I_W    = INT_W + KI_W + 1;
	localparam int TOT_W  = tot_width(ADC_BITS);

	// stage registers
	logic                   valid_s1;
	logic [ADC_BITS-1:0]    sample_s1;
	logic                   valid_s2;
	logic                   cut_s2;
	logic signed [P_W-1:0]  p_s2;
	logic signed [D_W-1:0]  d_s2;
	logic signed [I_W-1:0]  i_s2;
	logic                   valid_s3;
	logic                   cut_s3;
	logic signed [TOT_W-1:0] total_s3;

	// loop state
	logic signed [ERR_W-1:0] prev_err_q;
	logic signed [INT_W-1:0] integ_q;

	// stage readiness
	logic rdy1, rdy2, rdy3;

	// combinational terms of the first stage
	logic [CMP_W-1:0]         smp_ext;
	logic [CMP_W-1:0]         zero_ext;
	logic                     cut_n;
	logic signed [ERR_W-1:0]  err_n;
	logic signed [DIFF_W-1:0] diff_n;
	logic signed [ISUM_W-1:0] isum_raw;
	logic signed [ISUM_W-1:0] lim_s;
	logic signed [ISUM_W-1:0] isum_c;
	logic signed [INT_W-1:0]  isum_n;
	logic signed [P_W-1:0]    p_n;
	logic signed [D_W-1:0]    d_n;
	logic signed [I_W-1:0]    i_n;
	logic signed [TOT_W-1:0]  total_n;

	// a stage loads when empty or when its word moves on
	assign rdy3         = !valid_s3 || take;
	assign rdy2         = !valid_s2 || rdy3;
	assign rdy1         = !valid_s1 || rdy2;
	assign sample_stall = !rdy1;

	// error, safe band, derivative, clamped integral and the gain products
	always_comb begin
		smp_ext  = CMP_W'(sample_s1);
		zero_ext = CMP_W'(cfg.zero_offset);
		cut_n    = (smp_ext > CMP_W'(cfg.safe_high)) || (smp_ext < CMP_W'(cfg.safe_low));
		err_n    = $signed({1'b0, zero_ext}) - $signed({1'b0, smp_ext});
		diff_n   = (prev_err_q == '0) ? '0 : (DIFF_W'(err_n) - DIFF_W'(prev_err_q));
		isum_raw = ISUM_W'(integ_q) + ISUM_W'(err_n) + ISUM_W'(prev_err_q);
		lim_s    = ISUM_W'($signed({1'b0, cfg.int_lim}));
		if (isum_raw > lim_s)
			isum_c = lim_s;
		else if (isum_raw < -lim_s)
			isum_c = -lim_s;
		else
			isum_c = isum_raw;
		isum_n = INT_W'(isum_c);
		p_n    = err_n * $signed({1'b0, cfg.kp});
		d_n    = diff_n * $signed({1'b0, cfg.kd});
		i_n    = isum_n * $signed({1'b0, cfg.ki});
	end

	// align the products on the integral fraction point and add
	assign total_n = (TOT_W'(p_s2) <<< GAIN_SHIFT) + (TOT_W'(d_s2) <<< GAIN_SHIFT)
		+ TOT_W'(i_s2);

	// valid bits and loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			valid_s3   <= 1'b0;
			prev_err_q <= '0;
			integ_q    <= '0;
		end else begin
			if (rdy1)
				valid_s1 <= sample_valid;
			if (rdy2)
				valid_s2 <= valid_s1;
			if (rdy3)
				valid_s3 <= valid_s2;
			// advance the loop state as a word leaves the first stage
			if (rdy2 && valid_s1) begin
				prev_err_q <= err_n;
				integ_q    <= isum_n;
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (rdy1)
			sample_s1 <= sample;
		if (rdy2) begin
			cut_s2 <= cut_n;
			p_s2   <= p_n;
			d_s2   <= d_n;
			i_s2   <= i_n;
		end
		if (rdy3) begin
			cut_s3   <= cut_s2;
			total_s3 <= total_n;
		end
	end

	assign word_valid = valid_s3;
	assign word_cut   = cut_s3;
	assign word_total = total_s3;

endmodule

// ----- hw/rtl/pdc_drive.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdc_drive
// Round and saturate the PID sum to a duty, grade it for the LED, apply the
// safe-band cutoff and the rail-to-rail hold, and register the result word.
// ----------------------------------------------------------------------------
module pdc_drive #(
	parameter int ADC_BITS       = pdc_pkg::ADC_BITS_DEF,
	parameter int DUTY_FRAC_BITS = pdc_pkg::DUTY_FRAC_BITS_DEF
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           word_valid,
	input  logic                                           word_cut,
	input  logic signed [pdc_pkg::tot_width(ADC_BITS)-1:0] word_total,
	output logic                                           take,
	output logic                                           result_valid,
	input  logic                                           result_stall,
	output logic signed [DUTY_FRAC_BITS:0]                 duty,
	output logic signed [DUTY_FRAC_BITS:0]                 left_drive,
	output logic signed [DUTY_FRAC_BITS:0]                 right_drive,
	output logic [1:0]                                     led_level,
	output logic                                           cutoff,
	output logic                                           held
);
	import pdc_pkg::*;

	localparam int TOT_W = tot_width(ADC_BITS);
	localparam int DW    = DUTY_FRAC_BITS + 1;
	localparam int QW    = TOT_W + 1 - SUM_FRAC;
	localparam logic signed [DW-1:0] DUTY_MAX = DW'((1 << DUTY_FRAC_BITS) - 1);
	localparam logic signed [DW-1:0] LED_THR  = DW'((4 << DUTY_FRAC_BITS) / 5);

	// LED grades
	localparam logic [1:0] LED_NEG_FULL = 2'd0;
	localparam logic [1:0] LED_NEG      = 2'd1;
	localparam logic [1:0] LED_POS      = 2'd2;
	localparam logic [1:0] LED_POS_FULL = 2'd3;

	logic                    neg;
	logic [TOT_W-1:0]        mag;
	logic [TOT_W:0]          rnd;
	logic [QW-1:0]           q;
	logic [DUTY_FRAC_BITS-1:0] mag_d;
	logic signed [DW-1:0]    pid;
	logic [1:0]              led_n;
	logic signed [DW-1:0]    pd;
	logic                    jump;
	logic signed [DW-1:0]    duty_n;
	logic                    held_n;

	logic                    valid_q;
	logic signed [DW-1:0]    duty_q;
	logic signed [DW-1:0]    neg_duty_q;
	logic [1:0]              led_q;
	logic                    cut_q;
	logic                    held_q;
	logic signed [DW-1:0]    prev_duty_q;
	logic signed [DW-1:0]    older_duty_q;

	assign take = !valid_q || !result_stall;

	// round to nearest duty step, ties away from zero, then saturate
	always_comb begin
		neg   = word_total[TOT_W-1];
		mag   = neg ? TOT_W'(-word_total) : TOT_W'(word_total);
		rnd   = {1'b0, mag} + ((TOT_W + 1)'(1) << (SUM_FRAC - 1));
		q     = rnd[TOT_W:SUM_FRAC];
		mag_d = (|q[QW-1:DUTY_FRAC_BITS]) ? '1 : q[DUTY_FRAC_BITS-1:0];
		pid   = neg ? -$signed({1'b0, mag_d}) : $signed({1'b0, mag_d});
	end

	// grade the PID duty before cutoff and hold
	always_comb begin
		if (pid > LED_THR)
			led_n = LED_POS_FULL;
		else if (pid >= 0)
			led_n = LED_POS;
		else if (pid >= -LED_THR)
			led_n = LED_NEG;
		else
			led_n = LED_NEG_FULL;
	end

	// cutoff first, then hold on a jump from one rail to the other
	always_comb begin
		pd     = (prev_duty_q == '0) ? pid : prev_duty_q;
		jump   = ((pd == DUTY_MAX) && (pid == -DUTY_MAX))
			|| ((pd == -DUTY_MAX) && (pid == DUTY_MAX));
		held_n = 1'b0;
		if (word_cut)
			duty_n = '0;
		else if (jump) begin
			duty_n = older_duty_q;
			held_n = 1'b1;
		end else
			duty_n = pid;
	end

	// valid bit and duty history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= 1'b0;
			prev_duty_q  <= '0;
			older_duty_q <= '0;
		end else if (take) begin
			valid_q <= word_valid;
			if (word_valid) begin
				older_duty_q <= pd;
				prev_duty_q  <= duty_n;
			end
		end
	end

	// result word, no reset
	always_ff @(posedge clk) begin
		if (take) begin
			duty_q     <= duty_n;
			neg_duty_q <= -duty_n;
			led_q      <= led_n;
			cut_q      <= word_cut;
			held_q     <= held_n;
		end
	end

	assign result_valid = valid_q;
	assign duty         = duty_q;
	assign left_drive   = duty_q;
	assign right_drive  = neg_duty_q;
	assign led_level    = led_q;
	assign cutoff       = cut_q;
	assign held         = held_q;

endmodule

// ----- hw/rtl/pendulum_pid_duty_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pendulum_pid_duty_controller
// PID angle controller for an inverted pendulum: one ADC sample in, one motor
// duty word out, with integrator clamp, safe-band cutoff and rail-jump hold.
//
//   channel   handshake                  payload
//   sample    sample_valid / sample_stall adc_sample
//   result    result_valid / result_stall duty, left_drive, right_drive,
//                                         led_level, cutoff, held
//   config    cfg_valid / cfg_ready       cfg_index, cfg_data
//
// One word accepted per cycle while the result side does not stall; a result
// passes the input register, product register, sum register and result register.
// Error and integrator state close at the product register; the
// duty history closes at the result register.
// Reset clears valid bits and loop state and loads the register defaults.
// A stalled result freezes only the stages behind it; empty stages still fill.
// ----------------------------------------------------------------------------
module pendulum_pid_duty_controller #(
	parameter int ADC_BITS       = pdc_pkg::ADC_BITS_DEF,
	parameter int DUTY_FRAC_BITS = pdc_pkg::DUTY_FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pdc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pdc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic [ADC_BITS-1:0]            adc_sample,
	input  logic                           sample_valid,
	output logic                           sample_stall,
	output logic signed [DUTY_FRAC_BITS:0] duty,
	output logic signed [DUTY_FRAC_BITS:0] left_drive,
	output logic signed [DUTY_FRAC_BITS:0] right_drive,
	output logic [1:0]                     led_level,
	output logic                           cutoff,
	output logic                           held,
	output logic                           result_valid,
	input  logic                           result_stall
);
	import pdc_pkg::*;

	localparam int TOT_W = tot_width(ADC_BITS);

	cfg_t                    cfg;
	logic                    take;
	logic                    word_valid;
	logic                    word_cut;
	logic signed [TOT_W-1:0] word_total;

	// configuration registers
	pdc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// error, integral and gain products
	pdc_pid_core #(
		.ADC_BITS (ADC_BITS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.sample       (adc_sample),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.take         (take),
		.word_valid   (word_valid),
		.word_cut     (word_cut),
		.word_total   (word_total)
	);

	// duty shaping and result register
	pdc_drive #(
		.ADC_BITS       (ADC_BITS),
		.DUTY_FRAC_BITS (DUTY_FRAC_BITS)
	) u_drive (
		.clk          (clk),
		.arst_n       (arst_n),
		.word_valid   (word_valid),
		.word_cut     (word_cut),
		.word_total   (word_total),
		.take         (take),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.duty         (duty),
		.left_drive   (left_drive),
		.right_drive  (right_drive),
		.led_level    (led_level),
		.cutoff       (cutoff),
		.held         (held)
	);

`ifndef ASSERT_OFF
	// a cut word carries no drive and is never a held word
	a_cut_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && cutoff |-> (duty == '0) && !held)
		else $error("cutoff word with non-zero duty or hold");

	// an empty result register never back-pressures the sample side
	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> !sample_stall)
		else $error("sample stalled while result register empty");

	// saturation is symmetric: the most negative code never appears
	a_sym_sat: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> duty != {1'b1, {DUTY_FRAC_BITS{1'b0}}})
		else $error("duty outside symmetric range");

	// the right motor always mirrors the left
	a_mirror: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (right_drive + left_drive) == '0)
		else $error("right drive does not mirror left drive");
`endif

endmodule

// ----- tb/pendulum_pid_duty_controller_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pendulum_pid_duty_controller_tb
// Self-checking bench for the pendulum PID duty controller. Angle samples and
// register writes are driven over their handshakes. Every accepted sample is
// run through a local copy of the control law (error, clamped trapezoidal
// integral, gated derivative, rounding, cutoff and rail-jump hold). The drive
// word it gives is queued and compared field by field with the next result.
// ----------------------------------------------------------------------------
module pendulum_pid_duty_controller_tb;
	import pdc_pkg::*;

	localparam int     ADC_W          = ADC_BITS_DEF;
	localparam int     ADC_MAX        = (1 << ADC_W) - 1;
	localparam int     ERR_W          = ADC_W + 1;
	localparam int     DUTY_W         = DUTY_FRAC_BITS_DEF + 1;
	localparam longint DUTY_RAIL      = (longint'(1) << DUTY_FRAC_BITS_DEF) - 1;
	localparam longint LED_EDGE       = (longint'(4) << DUTY_FRAC_BITS_DEF) / 5;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(7);
	localparam int     RESET_CYCLES   = 6;
	localparam int     STALL_HOLD     = 64;
	localparam int     WATCHDOG_LIMIT = 1000;
	localparam int     DRAIN_CYCLES   = 8;
	localparam int     RANDOM_PHASES  = 10;
	localparam int     PHASE_ITEMS    = 75;
	localparam int     MAX_REPORTS    = 100;

	// LED level codes
	localparam logic [1:0] LED_NEG_FULL = 2'd0;
	localparam logic [1:0] LED_NEG      = 2'd1;
	localparam logic [1:0] LED_POS      = 2'd2;
	localparam logic [1:0] LED_POS_FULL = 2'd3;

	typedef struct {
		logic signed [DUTY_W-1:0] duty;
		logic signed [DUTY_W-1:0] left_drive;
		logic signed [DUTY_W-1:0] right_drive;
		logic [1:0]               led_level;
		logic                     cutoff;
		logic                     held;
	} drive_word_t;

	logic                        clk          = 1'b0;
	logic                        arst_n       = 1'b0;
	logic                        cfg_valid    = 1'b0;
	logic                        cfg_ready;
	logic [CFG_IDX_W-1:0]        cfg_index    = REG_KP;
	logic [CFG_DATA_W-1:0]       cfg_data     = '0;
	logic [ADC_W-1:0]            adc_sample   = '0;
	logic                        sample_valid = 1'b0;
	logic                        sample_stall;
	logic signed [DUTY_W-1:0]    duty;
	logic signed [DUTY_W-1:0]    left_drive;
	logic signed [DUTY_W-1:0]    right_drive;
	logic [1:0]                  led_level;
	logic                        cutoff;
	logic                        held;
	logic                        result_valid;
	logic                        result_stall = 1'b0;

	// controller copy: registers and loop state
	cfg_t                        ctl;
	logic signed [ERR_W-1:0]     last_err     = '0;
	logic signed [INT_W-1:0]     integ        = '0;
	logic signed [DUTY_W-1:0]    last_duty    = '0;
	logic signed [DUTY_W-1:0]    older_duty   = '0;
	drive_word_t                 drive_q[$];

	int                          errors       = 0;
	int                          stall_cnt    = 0;
	int                          hold_cnt     = 0;
	int                          quiet_cycles = 0;
	bit                          idle_on      = 1'b1;
	bit                          hold_request = 1'b0;

	pendulum_pid_duty_controller u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.adc_sample   (adc_sample),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.duty         (duty),
		.left_drive   (left_drive),
		.right_drive  (right_drive),
		.led_level    (led_level),
		.cutoff       (cutoff),
		.held         (held),
		.result_valid (result_valid),
		.result_stall (result_stall)
	);

	always #1 clk = ~clk;

	function automatic cfg_t make_setup(input logic [31:0] kp, input logic [31:0] ki,
			input logic [31:0] kd, input logic [31:0] lim, input int zero, input int hi,
			input int lo);
		cfg_t c;
		c.kp          = kp[KP_W-1:0];
		c.ki          = ki[KI_W-1:0];
		c.kd          = kd[KD_W-1:0];
		c.int_lim     = lim[LIM_W-1:0];
		c.zero_offset = ADCFG_W'(zero);
		c.safe_high   = ADCFG_W'(hi);
		c.safe_low    = ADCFG_W'(lo);
		return c;
	endfunction

	// fill the bits above the register width with noise
	function automatic logic [CFG_DATA_W-1:0] with_noise(input logic [31:0] v, input int w);
		logic [31:0] n;
		n = $urandom;
		return CFG_DATA_W'((n << w) | (v & ((32'd1 << w) - 1)));
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("%0t ns: %s mismatch: got %0d, expected %0d", $time, what, got, want);
	endtask

	// advance the controller copy by one sample and queue its drive word
	task automatic compute_drive(input logic [ADC_W-1:0] s);
		longint         err, diff, isum, lim, total, dv, pd;
		longint unsigned mag, q;
		drive_word_t    w;
		err  = longint'(ctl.zero_offset) - longint'(s);
		diff = (last_err == 0) ? 0 : err - longint'(last_err);
		lim  = longint'(ctl.int_lim);
		isum = longint'(integ) + err + longint'(last_err);
		if (isum > lim)
			isum = lim;
		if (isum < -lim)
			isum = -lim;
		integ    = INT_W'(isum);
		last_err = ERR_W'(err);

		total = ((err * longint'(ctl.kp)) <<< GAIN_SHIFT)
		      + ((diff * longint'(ctl.kd)) <<< GAIN_SHIFT)
		      + isum * longint'(ctl.ki);

		// round half away from zero, then saturate at the rails
		mag = (total < 0) ? -total : total;
		q   = (mag + (longint'(1) << (SUM_FRAC - 1))) >> SUM_FRAC;
		if (q > DUTY_RAIL)
			q = DUTY_RAIL;
		dv = (total < 0) ? -longint'(q) : longint'(q);

		if (dv > LED_EDGE)
			w.led_level = LED_POS_FULL;
		else if (dv >= 0)
			w.led_level = LED_POS;
		else if (dv >= -LED_EDGE)
			w.led_level = LED_NEG;
		else
			w.led_level = LED_NEG_FULL;

		// drive stage: cutoff wins over the rail-jump hold
		pd       = (last_duty == 0) ? dv : longint'(last_duty);
		w.cutoff = 1'b0;
		w.held   = 1'b0;
		if (s > ctl.safe_high || s < ctl.safe_low) begin
			dv       = 0;
			w.cutoff = 1'b1;
		end else if (pd - dv == 2 * DUTY_RAIL || pd - dv == -2 * DUTY_RAIL) begin
			dv     = longint'(older_duty);
			w.held = 1'b1;
		end
		older_duty = DUTY_W'(pd);
		last_duty  = DUTY_W'(dv);

		w.duty        = DUTY_W'(dv);
		w.left_drive  = DUTY_W'(dv);
		w.right_drive = DUTY_W'(-dv);
		drive_q.push_back(w);
	endtask

	// offer one sample word, after a random gap when idling is on
	task automatic send_sample(input logic [ADC_W-1:0] s);
		int gap;
		gap = idle_on ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		adc_sample   <= s;
		do @(posedge clk); while (sample_stall);
		compute_drive(s);
	endtask

	// write one register; valid is left high for a following write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_KP:      ctl.kp          = data[KP_W-1:0];
			REG_KI:      ctl.ki          = data[KI_W-1:0];
			REG_KD:      ctl.kd          = data[KD_W-1:0];
			REG_INT_LIM: ctl.int_lim     = data[LIM_W-1:0];
			REG_ZERO:    ctl.zero_offset = data[ADCFG_W-1:0];
			REG_SAFE_HI: ctl.safe_high   = data[ADCFG_W-1:0];
			REG_SAFE_LO: ctl.safe_low    = data[ADCFG_W-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_setup(input cfg_t c, input bit spare);
		write_reg(REG_KP,      with_noise(c.kp, KP_W));
		write_reg(REG_KI,      with_noise(c.ki, KI_W));
		write_reg(REG_KD,      with_noise(c.kd, KD_W));
		write_reg(REG_INT_LIM, with_noise(c.int_lim, LIM_W));
		write_reg(REG_ZERO,    with_noise(c.zero_offset, ADCFG_W));
		write_reg(REG_SAFE_HI, with_noise(c.safe_high, ADCFG_W));
		write_reg(REG_SAFE_LO, with_noise(c.safe_low, ADCFG_W));
		// an unmapped index must leave every register alone
		if (spare)
			write_reg(REG_SPARE, CFG_DATA_W'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// drop the sample valid and wait for the pipeline to empty
	task automatic settle();
		sample_valid <= 1'b0;
		while (drive_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_level(input int w, input int unsigned typical);
		logic [31:0] full;
		full = (32'd1 << w) - 1;
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return full;
			2: return $urandom & full;
			default: return $urandom_range(0, typical);
		endcase
	endfunction

	function automatic cfg_t random_setup();
		int zero, hi, lo;
		zero = $urandom_range(0, ADC_MAX);
		case ($urandom_range(0, 5))
			0: begin
				hi = ADC_MAX;
				lo = 0;
			end
			1: begin
				hi = $urandom_range(0, ADC_MAX);
				lo = $urandom_range(0, ADC_MAX);
			end
			default: begin
				hi = zero + int'($urandom_range(0, 200));
				lo = zero - int'($urandom_range(0, 200));
				if (hi > ADC_MAX)
					hi = ADC_MAX;
				if (lo < 0)
					lo = 0;
			end
		endcase
		return make_setup(pick_level(KP_W, 400000), pick_level(KI_W, 2000000),
			pick_level(KD_W, 40000000), pick_level(LIM_W, 3000), zero, hi, lo);
	endfunction

	// mostly small moves round upright, with exact upright, rails and noise mixed in
	function automatic logic [ADC_W-1:0] random_sample();
		int v;
		case ($urandom_range(0, 9))
			0:       v = ctl.zero_offset;
			1, 2:    v = $urandom_range(0, ADC_MAX);
			3:       v = $urandom_range(0, 1) ? 0 : ADC_MAX;
			default: v = int'(ctl.zero_offset) + int'($urandom_range(0, 80)) - 40;
		endcase
		if (v < 0)
			v = 0;
		if (v > ADC_MAX)
			v = ADC_MAX;
		return ADC_W'(v);
	endfunction

	// check each result word, pace the result stall
	always @(posedge clk) begin : drive_checker
		drive_word_t w;
		if (arst_n && result_valid && !result_stall) begin
			if (drive_q.size() == 0) begin
				report_mismatch("unexpected result duty", duty, 0);
			end else begin
				w = drive_q.pop_front();
				if (duty !== w.duty)
					report_mismatch("duty", duty, w.duty);
				if (left_drive !== w.left_drive)
					report_mismatch("left_drive", left_drive, w.left_drive);
				if (right_drive !== w.right_drive)
					report_mismatch("right_drive", right_drive, w.right_drive);
				if (led_level !== w.led_level)
					report_mismatch("led_level", led_level, w.led_level);
				if (cutoff !== w.cutoff)
					report_mismatch("cutoff", cutoff, w.cutoff);
				if (held !== w.held)
					report_mismatch("held", held, w.held);
			end
			stall_cnt = idle_on ? $urandom_range(0, 3) : 0;
		end
		if (hold_request) begin
			hold_request = 1'b0;
			hold_cnt     = STALL_HOLD;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			result_stall <= 1'b1;
		end else if (stall_cnt > 0) begin
			stall_cnt--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	// end the run when no word moves for too long
	always @(posedge clk) begin : watchdog
		if ((sample_valid && !sample_stall) || (result_valid && !result_stall)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("pendulum_pid_duty_controller test failed");
				$finish;
			end
		end
	end

	// reset gains: upright, first tick and zero previous error
	task automatic test_reset_defaults();
		send_sample(ADC_W'(423));
		send_sample(ADC_W'(430));
		send_sample(ADC_W'(423));
		send_sample(ADC_W'(400));
		send_sample(ADC_W'(450));
		send_sample(ADC_W'(423));
	endtask

	// reset band edges and both ends of the ADC range
	task automatic test_band_edges();
		send_sample(ADC_W'(249));
		send_sample(ADC_W'(250));
		send_sample(ADC_W'(520));
		send_sample(ADC_W'(521));
		send_sample(ADC_W'(0));
		send_sample(ADC_W'(ADC_MAX));
	endtask

	// saturated swings between rails: hold, and cutoff taking priority
	task automatic test_rail_hold();
		settle();
		apply_setup(make_setup((32'd1 << KP_W) - 1, 0, 0, 0, 512, ADC_MAX - 1, 0), 1'b0);
		send_sample(ADC_W'(0));
		send_sample(ADC_W'(ADC_MAX - 1));
		send_sample(ADC_W'(0));
		send_sample(ADC_W'(ADC_MAX));
		send_sample(ADC_W'(0));
		send_sample(ADC_W'(ADC_MAX - 1));
	endtask

	// low limit above high limit cuts every sample
	task automatic test_inverted_band();
		settle();
		apply_setup(make_setup(KP_RST, KI_RST, KD_RST, LIM_RST, 512, 300, 700), 1'b0);
		send_sample(ADC_W'(500));
		send_sample(ADC_W'(512));
	endtask

	// every gain and the limit at full scale, then all at zero
	task automatic test_gain_extremes();
		settle();
		apply_setup(make_setup((32'd1 << KP_W) - 1, (32'd1 << KI_W) - 1,
			(32'd1 << KD_W) - 1, (32'd1 << LIM_W) - 1, 0, ADC_MAX, 0), 1'b1);
		send_sample(ADC_W'(ADC_MAX));
		send_sample(ADC_W'(0));
		send_sample(ADC_W'(5));
		settle();
		apply_setup(make_setup(0, 0, 0, 0, ADC_MAX, ADC_MAX, 0), 1'b0);
		send_sample(ADC_W'(0));
		send_sample(ADC_W'(ADC_MAX));
	endtask

	// random settings per phase; phases 1, 5 and 9 without idling, phase 3 under a long stall
	task automatic test_random_traffic();
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			settle();
			apply_setup(random_setup(), p == 2);
			idle_on = (p % 4) != 1;
			if (p == 3)
				hold_request = 1'b1;
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_sample(random_sample());
		end
	endtask

	initial begin
		ctl = make_setup(KP_RST, KI_RST, KD_RST, LIM_RST, ZERO_RST, SAFE_HI_RST, SAFE_LO_RST);
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_band_edges();
		test_rail_hold();
		test_inverted_band();
		test_gain_extremes();
		test_random_traffic();
		settle();
		if (errors == 0 && drive_q.size() == 0)
			$display("pendulum_pid_duty_controller test passed");
		else
			$display("pendulum_pid_duty_controller test failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/pdc_pkg.sv
hw/rtl/pdc_cfg_regs.sv
hw/rtl/pdc_pid_core.sv
hw/rtl/pdc_drive.sv
hw/rtl/pendulum_pid_duty_controller.sv
tb/pendulum_pid_duty_controller_tb.sv
